FILE: rtl/psc_pkg.sv
// Shared types, codes, constants and the mode transition table of the pump state controller.
package psc_pkg;

    localparam int PERIOD_BITS_DEF = 32;
    localparam int TIMER_BITS_DEF  = 32;

    localparam logic [31:0] SAFETY_TICKS_RESET = 32'd300;

    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_STARTING = 3'd1,
        MODE_RUNNING  = 3'd2,
        MODE_TIMEOUT  = 3'd3,
        MODE_ERROR    = 3'd4,
        MODE_MAINT    = 3'd5
    } t_mode;

    // Command codes as they arrive on the input stream.
    localparam logic [3:0] CMD_PLATEAU    = 4'd0;
    localparam logic [3:0] CMD_TIMEOUT    = 4'd1;
    localparam logic [3:0] CMD_SAFETY     = 4'd2;
    localparam logic [3:0] CMD_ERROR      = 4'd3;
    localparam logic [3:0] CMD_MAINT_IN   = 4'd4;
    localparam logic [3:0] CMD_MAINT_OUT  = 4'd5;
    localparam logic [3:0] CMD_RESET      = 4'd6;
    localparam logic [3:0] CMD_TURN_ON    = 4'd7;
    localparam logic [3:0] CMD_UPDATE     = 4'd8;
    localparam logic [3:0] CMD_ESTOP      = 4'd9;
    localparam logic [3:0] CMD_TICK       = 4'd10;

    // Table events, the low bits of the first seven commands.
    localparam logic [2:0] EV_PLATEAU   = 3'd0;
    localparam logic [2:0] EV_TIMEOUT   = 3'd1;
    localparam logic [2:0] EV_SAFETY    = 3'd2;
    localparam logic [2:0] EV_ERROR     = 3'd3;
    localparam logic [2:0] EV_MAINT_IN  = 3'd4;
    localparam logic [2:0] EV_MAINT_OUT = 3'd5;
    localparam logic [2:0] EV_RESET     = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADARG = 2'd1;
    localparam logic [1:0] ST_DENIED = 2'd2;

    // One result item, declared from the highest bit down as it leaves on tdata.
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] ticks_left;
        logic [31:0] initial_period;
        logic [31:0] latest_period;
        logic        timer_expired;
        logic [1:0]  status;
        logic        pump_running;
        logic        relay_level;
        logic [2:0]  state_before;
        logic [2:0]  state_now;
    } t_result;

    function automatic t_mode next_mode(input t_mode mode, input logic [2:0] ev);
        t_mode target;
        target = mode;
        case (mode)
            MODE_OFF: begin
                case (ev)
                    EV_PLATEAU:  target = MODE_STARTING;
                    EV_ERROR:    target = MODE_ERROR;
                    EV_MAINT_IN: target = MODE_MAINT;
                    default:     target = MODE_OFF;
                endcase
            end
            MODE_STARTING: begin
                case (ev)
                    EV_PLATEAU:   target = MODE_RUNNING;
                    EV_TIMEOUT:   target = MODE_TIMEOUT;
                    EV_SAFETY:    target = MODE_ERROR;
                    EV_ERROR:     target = MODE_ERROR;
                    EV_MAINT_IN:  target = MODE_MAINT;
                    EV_MAINT_OUT: target = MODE_OFF;
                    EV_RESET:     target = MODE_OFF;
                    default:      target = MODE_STARTING;
                endcase
            end
            MODE_RUNNING: begin
                case (ev)
                    EV_TIMEOUT:  target = MODE_TIMEOUT;
                    EV_SAFETY:   target = MODE_OFF;
                    EV_ERROR:    target = MODE_ERROR;
                    EV_MAINT_IN: target = MODE_MAINT;
                    EV_RESET:    target = MODE_OFF;
                    default:     target = MODE_RUNNING;
                endcase
            end
            MODE_TIMEOUT: begin
                case (ev)
                    EV_PLATEAU:  target = MODE_OFF;
                    EV_SAFETY:   target = MODE_OFF;
                    EV_ERROR:    target = MODE_ERROR;
                    EV_MAINT_IN: target = MODE_MAINT;
                    EV_RESET:    target = MODE_OFF;
                    default:     target = MODE_TIMEOUT;
                endcase
            end
            MODE_ERROR: begin
                case (ev)
                    EV_SAFETY:   target = MODE_OFF;
                    EV_MAINT_IN: target = MODE_MAINT;
                    EV_RESET:    target = MODE_OFF;
                    default:     target = MODE_ERROR;
                endcase
            end
            MODE_MAINT: begin
                case (ev)
                    EV_MAINT_OUT: target = MODE_OFF;
                    EV_RESET:     target = MODE_OFF;
                    default:      target = MODE_MAINT;
                endcase
            end
            default: target = mode;
        endcase
        return target;
    endfunction

endpackage

FILE: rtl/psc_in_reg.sv
// Input register of the pump state controller: holds one command item until it is processed.
module psc_in_reg import psc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] period
    input  logic [3:0]  s_axis_tuser,   // [3:0] command
    input  logic        i_advance,
    output logic        o_valid,
    output logic [3:0]  o_command,
    output logic [31:0] o_period
);

    logic        r_valid;
    logic [3:0]  r_command;
    logic [31:0] r_period;

    // The register frees up in the same cycle as its item moves on.
    assign s_axis_tready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_command <= s_axis_tuser;
            r_period  <= s_axis_tdata;
        end
    end

    assign o_valid   = r_valid;
    assign o_command = r_command;
    assign o_period  = r_period;

endmodule

FILE: rtl/psc_step.sv
// Combinational step of the pump state controller: next mode, counters and the result item.
module psc_step import psc_pkg::*; #(
    parameter int PERIOD_BITS = PERIOD_BITS_DEF,
    parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
    input  logic [3:0]             i_command,
    input  logic [31:0]            i_period,
    input  logic [31:0]            i_safety_ticks,
    input  t_mode                  i_mode,
    input  t_mode                  i_prior,
    input  logic [PERIOD_BITS-1:0] i_start_period,
    input  logic [PERIOD_BITS-1:0] i_last_period,
    input  logic [TIMER_BITS-1:0]  i_count,
    output t_mode                  o_mode,
    output t_mode                  o_prior,
    output logic [PERIOD_BITS-1:0] o_start_period,
    output logic [PERIOD_BITS-1:0] o_last_period,
    output logic [TIMER_BITS-1:0]  o_count,
    output t_result                o_result
);

    logic [PERIOD_BITS-1:0] per;
    logic                   move_req;
    t_mode                  target;
    logic [1:0]             status;
    logic                   expired;

    assign per = PERIOD_BITS'(i_period);

    always_comb begin
        move_req       = 1'b0;
        target         = i_mode;
        status         = ST_OK;
        expired        = 1'b0;
        o_start_period = i_start_period;
        o_last_period  = i_last_period;
        o_count        = i_count;
        o_mode         = i_mode;
        o_prior        = i_prior;

        case (i_command)
            CMD_PLATEAU, CMD_TIMEOUT, CMD_SAFETY, CMD_ERROR,
            CMD_MAINT_IN, CMD_MAINT_OUT, CMD_RESET: begin
                move_req = 1'b1;
                target   = next_mode(i_mode, i_command[2:0]);
            end
            CMD_TURN_ON: begin
                if (per == '0) begin
                    status = ST_BADARG;
                end else if (i_mode != MODE_OFF && i_mode != MODE_STARTING) begin
                    status = ST_DENIED;
                end else begin
                    o_start_period = per;
                    o_last_period  = per;
                    move_req       = 1'b1;
                    target         = next_mode(i_mode, EV_PLATEAU);
                end
            end
            CMD_UPDATE: begin
                // A plateau event from running leads back to running, so no move.
                if (per == '0) begin
                    status = ST_BADARG;
                end else begin
                    o_last_period = per;
                end
            end
            CMD_ESTOP: begin
                move_req = 1'b1;
                target   = MODE_OFF;
            end
            CMD_TICK: begin
                if (i_mode == MODE_RUNNING) begin
                    if (i_count <= TIMER_BITS'(1)) begin
                        move_req = 1'b1;
                        target   = MODE_OFF;
                        expired  = 1'b1;
                    end else begin
                        o_count = i_count - TIMER_BITS'(1);
                    end
                end
            end
            default: status = ST_BADARG;
        endcase

        if (move_req && target != i_mode) begin
            o_prior = i_mode;
            o_mode  = target;
            if (i_mode == MODE_RUNNING) begin
                o_count = '0;
            end
            if (target == MODE_RUNNING) begin
                o_count = TIMER_BITS'(i_safety_ticks);
            end
        end
    end

    always_comb begin
        o_result                = '0;
        o_result.state_now      = o_mode;
        o_result.state_before   = o_prior;
        o_result.relay_level    = (o_mode != MODE_RUNNING);
        o_result.pump_running   = (o_mode == MODE_RUNNING);
        o_result.status         = status;
        o_result.timer_expired  = expired;
        o_result.latest_period  = 32'(o_last_period);
        o_result.initial_period = 32'(o_start_period);
        o_result.ticks_left     = (o_mode == MODE_RUNNING) ? 32'(o_count) : 32'd0;
    end

endmodule

FILE: rtl/pump_state_controller.sv
// Top level of the pump state controller: input register, mode state, result register.
//
// Each command item on the slave stream (command on tuser, period on tdata) produces
// exactly one result item on the master stream, carrying the mode after the command,
// the mode before the last change, the active-low relay level, the run flag, a status code,
// the safety-expiry flag, both stored periods and the remaining safety ticks. The block
// takes one item per clock cycle while the master side does not stall: an item waits in
// the input register, the transition table and counter step are evaluated in the same
// cycle as it leaves, and the result appears on the master stream on the following
// cycle. A new item can be accepted as soon as the held item moves on. Every item reads
// and writes the mode and counter registers. The safety tick limit is a plain write-only
// register, written with i_cfg_we, and takes effect on the next entry to running; it
// should only be changed while no items are in flight.
module pump_state_controller import psc_pkg::*; #(
    parameter int PERIOD_BITS = PERIOD_BITS_DEF,
    parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,     // safety_ticks
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,    // [31:0] period
    input  logic [3:0]   s_axis_tuser,    // [3:0] command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] state_now, [5:3] state_before, [6] relay_level, [7] pump_running,
    // [9:8] status, [10] timer_expired, [42:11] latest_period,
    // [74:43] initial_period, [106:75] ticks_left, [111:107] zero
    output logic [111:0] m_axis_tdata
);

    // Configuration register: number of ticks allowed in running.
    logic [31:0] r_safety_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safety_ticks <= SAFETY_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_safety_ticks <= i_cfg_wdata;
        end
    end

    // The held item moves on whenever the result register is empty or being drained.
    logic        in_valid;
    logic [3:0]  in_command;
    logic [31:0] in_period;
    logic        advance;
    logic        r_out_valid;

    assign advance = in_valid && (!r_out_valid || m_axis_tready);

    psc_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_advance     (advance),
        .o_valid       (in_valid),
        .o_command     (in_command),
        .o_period      (in_period)
    );

    // Controller state. It is only updated when an item moves into the result register.
    t_mode                  r_mode;
    t_mode                  r_prior;
    logic [PERIOD_BITS-1:0] r_start_period;
    logic [PERIOD_BITS-1:0] r_last_period;
    logic [TIMER_BITS-1:0]  r_count;

    t_mode                  n_mode;
    t_mode                  n_prior;
    logic [PERIOD_BITS-1:0] n_start_period;
    logic [PERIOD_BITS-1:0] n_last_period;
    logic [TIMER_BITS-1:0]  n_count;
    t_result                n_result;

    psc_step #(
        .PERIOD_BITS (PERIOD_BITS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_step (
        .i_command      (in_command),
        .i_period       (in_period),
        .i_safety_ticks (r_safety_ticks),
        .i_mode         (r_mode),
        .i_prior        (r_prior),
        .i_start_period (r_start_period),
        .i_last_period  (r_last_period),
        .i_count        (r_count),
        .o_mode         (n_mode),
        .o_prior        (n_prior),
        .o_start_period (n_start_period),
        .o_last_period  (n_last_period),
        .o_count        (n_count),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_OFF;
            r_prior        <= MODE_OFF;
            r_start_period <= '0;
            r_last_period  <= '0;
            r_count        <= '0;
        end else if (advance) begin
            r_mode         <= n_mode;
            r_prior        <= n_prior;
            r_start_period <= n_start_period;
            r_last_period  <= n_last_period;
            r_count        <= n_count;
        end
    end

    // Result register, which holds its item for as long as the master side stalls.
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_result;

    // An item held at the input and free to move must show up as a result next cycle.
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed item did not reach the result register");

    // An item that cannot move must stay in the input register.
    a_stalled_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && !advance) |=> in_valid)
        else $error("stalled input item was dropped");

    // A rejected command leaves the mode unchanged.
    a_reject_keeps_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_result.status != ST_OK) |=> (r_mode == $past(r_mode)))
        else $error("rejected command changed the mode");

    // A safety expiry always comes from running and lands in off.
    a_expiry_from_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_result.timer_expired) |->
            (r_mode == MODE_RUNNING && n_mode == MODE_OFF))
        else $error("safety expiry outside a running to off change");

    // The relay is driven on exactly while the result says running.
    a_relay_matches_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.relay_level != r_result.pump_running))
        else $error("relay level disagrees with the run flag");

endmodule
